### design/mmaq_pkg.sv
`default_nettype none

package mmaq_pkg;

  // Field widths fixed by the transaction format
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 7;

  // Default queue capacity
  localparam int QUEUE_DEPTH_DEF = 64;

  // Empty-window readings: greatest value for the minimum, least for the maximum
  localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } mmaq_kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } mmaq_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_XFER,
    S_POP,
    S_FILL
  } mmaq_state_t;

  typedef struct packed {
    mmaq_kind_t                    kind;
    logic signed [VALUE_BITS-1:0]  value;
  } mmaq_in_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  popped_value;
    mmaq_status_t                  status;
    logic signed [VALUE_BITS-1:0]  window_min;
    logic signed [VALUE_BITS-1:0]  window_max;
    logic [COUNT_BITS-1:0]         count;
  } mmaq_out_t;

  // One stack entry: value plus running min/max of itself and everything below
  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  value;
    logic signed [VALUE_BITS-1:0]  pmin;
    logic signed [VALUE_BITS-1:0]  pmax;
  } mmaq_entry_t;

  // Top-of-stack aggregate handed to the window merge
  typedef struct packed {
    logic                          live;
    logic signed [VALUE_BITS-1:0]  mn;
    logic signed [VALUE_BITS-1:0]  mx;
  } mmaq_top_t;

endpackage

`default_nettype wire

### design/mmaq_ram.sv
`default_nettype none

module mmaq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Single write port, single registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### design/mmaq_merge.sv
`default_nettype none

module mmaq_merge (
  input  wire mmaq_pkg::mmaq_top_t                 in_top,
  input  wire mmaq_pkg::mmaq_top_t                 ob_top,
  output logic signed [mmaq_pkg::VALUE_BITS-1:0]   win_min,
  output logic signed [mmaq_pkg::VALUE_BITS-1:0]   win_max
);

  import mmaq_pkg::*;

  // Combine the tops of both stacks; an empty stack contributes nothing
  always_comb begin
    win_min = VALUE_MAX;
    win_max = VALUE_MIN;
    if (ob_top.live) begin
      win_min = ob_top.mn;
      win_max = ob_top.mx;
    end
    if (in_top.live) begin
      if (!ob_top.live || ($signed(in_top.mn) < $signed(win_min))) begin
        win_min = in_top.mn;
      end
      if (!ob_top.live || ($signed(in_top.mx) > $signed(win_max))) begin
        win_max = in_top.mx;
      end
    end
  end

endmodule

`default_nettype wire

### design/min_max_aggregate_queue.sv
// Min/max aggregate FIFO built from two stacks (inbox and outbox) in RAM.
// Input channel in_valid/in_stall/in_data carries one transaction: a push of
// in_data.value or a pop of the oldest entry. Every transaction gives exactly
// one result on out_valid/out_stall/out_data: popped value, status, the
// window min/max of the contents after the operation and the element count.
// Path from acceptance to out_valid, the result always passing the output
// register: push, full push and pop on empty queue emit from S_IDLE; pop
// with outbox entries emits from S_FILL after reading back the new top; pop
// with empty outbox runs S_XFER, moving the N inbox entries across one per
// cycle through the inbox read port, then S_POP and S_FILL.
// One transaction is in flight at a time; the next is taken once the block
// is back in S_IDLE with the result slot free, so pushes run at one per
// cycle while out_stall is low, and plain pops also pass through S_FILL.
// The result sits in an output register; while out_stall is high it holds
// and a new transaction is taken only in the cycle the result leaves.
// Synchronous reset empties both stacks; RAM contents are not cleared and
// need no clearing pass, since only entries below the stack depth are read.

`default_nettype none

module min_max_aggregate_queue #(
  parameter int QUEUE_DEPTH = mmaq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire mmaq_pkg::mmaq_in_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output mmaq_pkg::mmaq_out_t       out_data
);

  import mmaq_pkg::*;

  localparam int DW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int EW = $bits(mmaq_entry_t);

  mmaq_state_t state_r, state_nxt;

  logic [DW-1:0] idepth_r, idepth_nxt;
  logic [DW-1:0] odepth_r, odepth_nxt;

  // Cached top-of-stack aggregates
  logic signed [VALUE_BITS-1:0] in_min_r, in_min_nxt;
  logic signed [VALUE_BITS-1:0] in_max_r, in_max_nxt;
  logic signed [VALUE_BITS-1:0] ob_min_r, ob_min_nxt;
  logic signed [VALUE_BITS-1:0] ob_max_r, ob_max_nxt;
  logic signed [VALUE_BITS-1:0] ob_val_r, ob_val_nxt;

  logic                         xfer_pend_r, xfer_pend_nxt;
  logic signed [VALUE_BITS-1:0] popped_r, popped_nxt;
  logic                         out_valid_r, out_valid_nxt;
  mmaq_out_t                    out_data_r, out_data_nxt;

  logic         accept;
  logic         emit;
  mmaq_status_t status_sel;
  logic [DW:0]  depth_sum;
  logic [DW:0]  depth_sum_nxt;
  logic         full;

  logic signed [VALUE_BITS-1:0] push_v, push_min, push_max;
  logic signed [VALUE_BITS-1:0] xv, x_min, x_max;

  logic          ib_we, ib_re, ob_we, ob_re;
  logic [AW-1:0] ib_waddr, ib_raddr, ob_waddr, ob_raddr;
  mmaq_entry_t   ib_wdata, ib_rdata, ob_wdata, ob_rdata;

  mmaq_top_t                    in_top, ob_top;
  logic signed [VALUE_BITS-1:0] win_min, win_max;

  // Handshake: take a transaction only when idle and the result slot frees
  assign in_stall = !((state_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign accept   = in_valid && !in_stall;

  assign depth_sum = {1'b0, idepth_r} + {1'b0, odepth_r};
  assign full      = depth_sum >= (DW+1)'(QUEUE_DEPTH);

  // Prefix aggregate for a push onto the inbox
  assign push_v   = in_data.value;
  assign push_min = ((idepth_r != '0) && ($signed(in_min_r) < $signed(push_v))) ?
                    in_min_r : push_v;
  assign push_max = ((idepth_r != '0) && ($signed(in_max_r) > $signed(push_v))) ?
                    in_max_r : push_v;

  // Prefix aggregate for an entry moved onto the outbox
  assign xv    = ib_rdata.value;
  assign x_min = ((odepth_r != '0) && ($signed(ob_min_r) < $signed(xv))) ? ob_min_r : xv;
  assign x_max = ((odepth_r != '0) && ($signed(ob_max_r) > $signed(xv))) ? ob_max_r : xv;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_data.kind == KIND_POP)) begin
          if (odepth_r != '0) begin
            state_nxt = S_FILL;
          end else if (idepth_r != '0) begin
            state_nxt = S_XFER;
          end
        end
      end
      S_XFER: begin
        if (idepth_r == '0) begin
          state_nxt = S_POP;
        end
      end
      S_POP:   state_nxt = S_FILL;
      S_FILL:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory accesses per state
  always_comb begin
    idepth_nxt    = idepth_r;
    odepth_nxt    = odepth_r;
    in_min_nxt    = in_min_r;
    in_max_nxt    = in_max_r;
    ob_min_nxt    = ob_min_r;
    ob_max_nxt    = ob_max_r;
    ob_val_nxt    = ob_val_r;
    xfer_pend_nxt = 1'b0;
    popped_nxt    = popped_r;
    emit          = 1'b0;
    status_sel    = ST_OK;
    ib_we         = 1'b0;
    ib_waddr      = idepth_r[AW-1:0];
    ib_wdata      = '{value: push_v, pmin: push_min, pmax: push_max};
    ib_re         = 1'b0;
    ib_raddr      = AW'(idepth_r - DW'(1));
    ob_we         = 1'b0;
    ob_waddr      = odepth_r[AW-1:0];
    ob_wdata      = '{value: xv, pmin: x_min, pmax: x_max};
    ob_re         = 1'b0;
    ob_raddr      = AW'(odepth_r - DW'(2));
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.kind == KIND_PUSH) begin
            emit       = 1'b1;
            popped_nxt = '0;
            if (full) begin
              status_sel = ST_FULL;
            end else begin
              ib_we      = 1'b1;
              in_min_nxt = push_min;
              in_max_nxt = push_max;
              idepth_nxt = idepth_r + DW'(1);
            end
          end else if (odepth_r != '0) begin
            // Pop the cached top, fetch the entry below it
            popped_nxt = ob_val_r;
            odepth_nxt = odepth_r - DW'(1);
            ob_re      = 1'b1;
          end else if (idepth_r == '0) begin
            emit       = 1'b1;
            popped_nxt = '0;
            status_sel = ST_EMPTY;
          end
        end
      end
      S_XFER: begin
        // Read the inbox top while writing the previous one to the outbox
        if (idepth_r != '0) begin
          ib_re         = 1'b1;
          idepth_nxt    = idepth_r - DW'(1);
          xfer_pend_nxt = 1'b1;
        end
        if (xfer_pend_r) begin
          ob_we      = 1'b1;
          ob_val_nxt = xv;
          ob_min_nxt = x_min;
          ob_max_nxt = x_max;
          odepth_nxt = odepth_r + DW'(1);
        end
      end
      S_POP: begin
        popped_nxt = ob_val_r;
        odepth_nxt = odepth_r - DW'(1);
        ob_re      = 1'b1;
      end
      S_FILL: begin
        if (odepth_r != '0) begin
          ob_val_nxt = ob_rdata.value;
          ob_min_nxt = ob_rdata.pmin;
          ob_max_nxt = ob_rdata.pmax;
        end
        emit = 1'b1;
      end
      default: begin
        idepth_nxt = idepth_r;
      end
    endcase
  end

  // Window over the state left by this transaction
  assign in_top = '{live: (idepth_nxt != '0), mn: in_min_nxt, mx: in_max_nxt};
  assign ob_top = '{live: (odepth_nxt != '0), mn: ob_min_nxt, mx: ob_max_nxt};

  mmaq_merge u_merge (
    .in_top  (in_top),
    .ob_top  (ob_top),
    .win_min (win_min),
    .win_max (win_max)
  );

  assign depth_sum_nxt = {1'b0, idepth_nxt} + {1'b0, odepth_nxt};

  // Result register
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.popped_value = popped_nxt;
      out_data_nxt.status       = status_sel;
      out_data_nxt.window_min   = win_min;
      out_data_nxt.window_max   = win_max;
      out_data_nxt.count        = COUNT_BITS'(depth_sum_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idepth_r    <= '0;
      odepth_r    <= '0;
      xfer_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idepth_r    <= idepth_nxt;
      odepth_r    <= odepth_nxt;
      xfer_pend_r <= xfer_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_min_r   <= in_min_nxt;
    in_max_r   <= in_max_nxt;
    ob_min_r   <= ob_min_nxt;
    ob_max_r   <= ob_max_nxt;
    ob_val_r   <= ob_val_nxt;
    popped_r   <= popped_nxt;
    out_data_r <= out_data_nxt;
  end

  // Inbox and outbox stacks
  mmaq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_inbox (
    .clk     (clk),
    .wr_en   (ib_we),
    .wr_addr (ib_waddr),
    .wr_data (ib_wdata),
    .rd_en   (ib_re),
    .rd_addr (ib_raddr),
    .rd_data (ib_rdata)
  );

  mmaq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_outbox (
    .clk     (clk),
    .wr_en   (ob_we),
    .wr_addr (ob_waddr),
    .wr_data (ob_wdata),
    .rd_en   (ob_re),
    .rd_addr (ob_raddr),
    .rd_data (ob_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### design/mmaq_checker.sv
`default_nettype none

module mmaq_checker #(
  parameter int QUEUE_DEPTH = mmaq_pkg::QUEUE_DEPTH_DEF
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire mmaq_pkg::mmaq_in_t   in_data,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire mmaq_pkg::mmaq_out_t  out_data
);

  import mmaq_pkg::*;

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Pop on empty queue leaves nothing behind and reports zero
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_EMPTY) |->
      (out_data.count == '0) && (out_data.popped_value == '0))
    else $error("empty pop with contents or value");

  // A dropped push only happens at capacity
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL) |->
      (out_data.count == COUNT_BITS'(QUEUE_DEPTH)) && (out_data.popped_value == '0))
    else $error("push dropped below capacity");

  // Empty window reads as the extreme values
  a_empty_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.count == '0) |->
      (out_data.window_min == VALUE_MAX) && (out_data.window_max == VALUE_MIN))
    else $error("empty window not at extremes");

  // Non-empty window is ordered
  a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.count != '0) |->
      ($signed(out_data.window_min) <= $signed(out_data.window_max)))
    else $error("window min above max");

endmodule

bind min_max_aggregate_queue mmaq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mmaq_checker (.*);

`default_nettype wire
